### rtl/pcbp_pkg.sv
// Package for the prefix code bit packer: sequencer states, transaction codes
// and fixed field widths. No dependencies.

package pcbp_pkg;

    localparam int BYTE_BITS       = 8;
    localparam int CODE_FIELD_BITS = 32;
    localparam int LEN_BITS        = 6;
    localparam int PEND_BITS       = 7;
    localparam int PEND_CNT_BITS   = 3;
    localparam int MAX_CODE_LEN    = 32;

    localparam logic [BYTE_BITS-1:0] END_MARKER = 8'hFF;

    // Kind of an input transaction, carried on s_tuser
    typedef enum logic [0:0] {
        OP_CODE = 1'b0,
        OP_END  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_MARK
    } state_t;

endpackage

### rtl/prefix_code_bit_packer.sv
// Prefix code bit packer top level: accumulator, byte sequencer, output register.
// Depends on pcbp_pkg.

// Packs right-aligned variable-length codewords into bytes, earliest bit in
// each byte's MSB. A code transaction (s_tuser = 0) appends the low
// code_length bits of code_bits (length saturated at the smaller of
// MAX_CODE_LEN and 32) to up to seven pending bits and sends every complete
// byte; the final byte it causes carries m_tlast. An end transaction
// (s_tuser = 1) sends the leftover bits zero-padded into one byte, if any,
// then the marker byte 0xFF with m_tlast, and empties the store. Rate: the
// input is taken in ST_IDLE, then one shared right shifter slices one byte per
// cycle out of the accumulator while m_tready is held high; a code transaction
// sends 0 to 4 bytes and an end transaction goes on through ST_EMIT to ST_MARK.
// s_tready is low until the sequencer is back in ST_IDLE, so no new transaction
// is taken before the last one is done; a byte waiting in the output register
// stalls the shifter.
module prefix_code_bit_packer #(
    parameter int MAX_CODE_LEN = pcbp_pkg::MAX_CODE_LEN
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] code_bits, [37:32] code_length, [39:38] zero
    input  logic [0:0]  s_tuser,   // [0] opcode
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] byte_value
    output logic        m_tlast
);

    // Widest usable code, accumulator and counter widths follow from it
    localparam int CW    = (MAX_CODE_LEN < pcbp_pkg::CODE_FIELD_BITS) ?
                           MAX_CODE_LEN : pcbp_pkg::CODE_FIELD_BITS;
    localparam int ACC_W = pcbp_pkg::PEND_BITS + CW;
    localparam int CNT_W = $clog2(ACC_W + 1);
    localparam int LEN_W = pcbp_pkg::LEN_BITS;
    localparam int BB    = pcbp_pkg::BYTE_BITS;

    // Registers
    pcbp_pkg::state_t                     state_reg, state_next;
    logic [ACC_W-1:0]                     acc_reg, acc_next;
    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic                                 end_reg, end_next;
    logic [pcbp_pkg::PEND_BITS-1:0]       pend_bits_reg, pend_bits_next;
    logic [pcbp_pkg::PEND_CNT_BITS-1:0]   pend_cnt_reg, pend_cnt_next;
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [BB-1:0]                        m_tdata_reg, m_tdata_next;
    logic                                 m_tlast_reg, m_tlast_next;

    // Input fields
    logic [pcbp_pkg::CODE_FIELD_BITS-1:0] code_bits;
    logic [LEN_W-1:0]                     code_length;
    pcbp_pkg::opcode_t                    opcode;

    assign code_bits   = s_tdata[pcbp_pkg::CODE_FIELD_BITS-1:0];
    assign code_length = s_tdata[pcbp_pkg::CODE_FIELD_BITS +: LEN_W];
    assign opcode      = pcbp_pkg::opcode_t'(s_tuser[0]);

    // Load path
    logic [LEN_W-1:0] eff_len;
    logic [CW-1:0]    code_masked;
    logic [BB-1:0]    pad_byte;

    assign eff_len     = (code_length > LEN_W'(CW)) ? LEN_W'(CW) : code_length;
    assign code_masked = code_bits[CW-1:0] & ({CW{1'b1}} >> (LEN_W'(CW) - eff_len));
    assign pad_byte    = BB'({1'b0, pend_bits_reg} << (LEN_W'(BB) - LEN_W'(pend_cnt_reg)));

    // Shared byte slicer
    logic [ACC_W-1:0] shifted;
    logic [CNT_W-1:0] rem;
    logic             have_byte;
    logic             slot_free;
    logic             emit_fire;
    logic             emit_done;
    logic [pcbp_pkg::PEND_CNT_BITS-1:0] left_cnt;

    assign have_byte = (cnt_reg >= CNT_W'(BB));
    assign rem       = have_byte ? (cnt_reg - CNT_W'(BB)) : cnt_reg;
    assign shifted   = acc_reg >> rem;
    assign slot_free = !m_tvalid_reg || m_tready;
    assign emit_fire = (state_reg == pcbp_pkg::ST_EMIT) && have_byte && slot_free;
    assign emit_done = (state_reg == pcbp_pkg::ST_EMIT) &&
                       (!have_byte || (slot_free && (rem < CNT_W'(BB))));
    assign left_cnt  = rem[pcbp_pkg::PEND_CNT_BITS-1:0];

    assign s_tready = (state_reg == pcbp_pkg::ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pcbp_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = pcbp_pkg::ST_EMIT;
            end
            pcbp_pkg::ST_EMIT:
            begin
                if (emit_done)
                    state_next = end_reg ? pcbp_pkg::ST_MARK : pcbp_pkg::ST_IDLE;
            end
            pcbp_pkg::ST_MARK:
            begin
                if (slot_free)
                    state_next = pcbp_pkg::ST_IDLE;
            end
            default:
                state_next = pcbp_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        end_next       = end_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;

        unique case (state_reg)
            pcbp_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (opcode == pcbp_pkg::OP_END)
                    begin
                        acc_next = ACC_W'(pad_byte);
                        cnt_next = (pend_cnt_reg != '0) ? CNT_W'(BB) : '0;
                        end_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = (ACC_W'(pend_bits_reg) << eff_len) | ACC_W'(code_masked);
                        cnt_next = CNT_W'(pend_cnt_reg) + CNT_W'(eff_len);
                        end_next = 1'b0;
                    end
                end
            end
            pcbp_pkg::ST_EMIT:
            begin
                if (emit_fire)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = shifted[BB-1:0];
                    m_tlast_next  = !end_reg && (rem < CNT_W'(BB));
                    cnt_next      = rem;
                end
                if (emit_done)
                begin
                    // keep what is left below a whole byte
                    pend_cnt_next  = left_cnt;
                    pend_bits_next = acc_reg[pcbp_pkg::PEND_BITS-1:0] &
                                     ~({pcbp_pkg::PEND_BITS{1'b1}} << left_cnt);
                end
            end
            pcbp_pkg::ST_MARK:
            begin
                if (slot_free)
                begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = pcbp_pkg::END_MARKER;
                    m_tlast_next   = 1'b1;
                    pend_bits_next = '0;
                    pend_cnt_next  = '0;
                end
            end
            default:
            begin
                m_tvalid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pcbp_pkg::ST_IDLE;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            m_tvalid_reg  <= 1'b0;
            end_reg       <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
            end_reg       <= end_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Assertions
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcbp_pkg::ST_EMIT) |-> (cnt_reg <= CNT_W'(ACC_W)))
        else $error("accumulator count beyond accumulator width");

    a_mark_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pcbp_pkg::ST_MARK && slot_free) |=>
        (m_tvalid && m_tlast && m_tdata == pcbp_pkg::END_MARKER &&
         pend_cnt_reg == '0 && state_reg == pcbp_pkg::ST_IDLE))
        else $error("end marker not issued or store not emptied");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && opcode == pcbp_pkg::OP_END) |=>
        (!s_tready && end_reg))
        else $error("end transaction not taken up by the sequencer");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && !end_reg && rem < CNT_W'(BB)) |=>
        (m_tlast && state_reg == pcbp_pkg::ST_IDLE))
        else $error("final byte of a code transaction without tlast");

endmodule

### test/testbench.sv
// Self-checking testbench for prefix_code_bit_packer: directed and random code and end
// transactions, a behavioural packer predictor and a byte-by-byte checker on the output.
// Depends on pcbp_pkg and the RTL top level.

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import pcbp_pkg::*;

    localparam int HOLD_CYCLES  = 80;      // long receiver hold-off, enough to back up the input
    localparam int SETTLE_TICKS = 20;      // quiet cycles after the last byte
    localparam int N_RANDOM     = 350;

    // One input transaction plus the flow-control setting it is sent under
    typedef struct {
        opcode_t     op;
        logic [31:0] bits;
        logic [5:0]  len;
        int unsigned src_idle;    // percent of cycles the sender sits idle
        int unsigned sink_stall;  // percent of cycles the receiver stalls
        bit          drain_first; // hold this one back until all bytes are out
        bit          hold_sink;   // receiver holds off for a long stretch after this one
    } code_item_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } packed_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // [31:0] code_bits, [37:32] code_length, [39:38] zero
    logic [0:0]  s_tuser = '0;     // [0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] byte_value
    logic        m_tlast;

    code_item_t   code_items[$];
    packed_byte_t bytes_due[$];

    // Predictor state: bits not yet sent, earliest bit highest, right-aligned
    logic [6:0]  spare_bits = '0;
    int unsigned spare_count = 0;

    int unsigned n_taken = 0;      // input transactions accepted (monitor)
    int unsigned n_retired = 0;    // input transactions popped (driver)
    int unsigned sink_stall = 0;
    int unsigned holds_asked = 0;
    int unsigned holds_granted = 0;
    int unsigned hold_left = 0;
    int unsigned mismatches = 0;
    bit          drained = 1'b0;

    prefix_code_bit_packer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Works out the bytes one input transaction causes and queues them in order
    task automatic pack_code_bits(input opcode_t op, input logic [31:0] bits,
                                  input logic [5:0] len_in);
        logic [63:0]  acc;
        int unsigned  len;
        int unsigned  count;
        int unsigned  n_bytes;
        packed_byte_t b;
        if (op == OP_END)
        begin
            // leftover bits go out zero-padded, then the marker closes the stream
            if (spare_count != 0)
            begin
                b.value = 8'(spare_bits) << (BYTE_BITS - spare_count);
                b.last  = 1'b0;
                bytes_due.push_back(b);
            end
            b.value = END_MARKER;
            b.last  = 1'b1;
            bytes_due.push_back(b);
            spare_bits  = '0;
            spare_count = 0;
        end
        else
        begin
            len = len_in;
            if (len > MAX_CODE_LEN)
                len = MAX_CODE_LEN;
            if (len > CODE_FIELD_BITS)
                len = CODE_FIELD_BITS;
            acc = (64'(spare_bits) << len) | (64'(bits) & ((64'd1 << len) - 64'd1));
            count = spare_count + len;
            n_bytes = count / BYTE_BITS;
            for (int i = 0; i < n_bytes; i++)
            begin
                b.value = 8'(acc >> (count - BYTE_BITS));
                b.last  = (i == n_bytes - 1);
                count -= BYTE_BITS;
                bytes_due.push_back(b);
            end
            spare_count = count;
            spare_bits  = 7'(acc & ((64'd1 << count) - 64'd1));
        end
    endtask

    task automatic add_item(input opcode_t op, input logic [31:0] bits, input logic [5:0] len,
                            input int unsigned src_idle, input int unsigned stall,
                            input bit drain_first, input bit hold_sink);
        code_item_t it;
        it.op          = op;
        it.bits        = bits;
        it.len         = len;
        it.src_idle    = src_idle;
        it.sink_stall  = stall;
        it.drain_first = drain_first;
        it.hold_sink   = hold_sink;
        code_items.push_back(it);
    endtask

    // Driver: offers the head of the queue, holds it until the monitor sees it taken
    always @(negedge clk)
    begin : drive
        logic holding;
        logic offer;
        if (rst_n)
        begin
            holding = s_tvalid && (n_taken == n_retired);
            if (n_taken != n_retired)
            begin
                code_items.pop_front();
                n_retired++;
                drained = 1'b0;
            end
            if (!holding)
            begin
                offer = 1'b0;
                if (code_items.size() != 0)
                begin
                    if (code_items[0].drain_first && !drained)
                    begin
                        if (bytes_due.size() == 0)
                            drained = 1'b1;
                    end
                    else if ($urandom_range(99) >= code_items[0].src_idle)
                        offer = 1'b1;
                end
                s_tvalid <= offer;
                if (offer)
                begin
                    s_tuser <= code_items[0].op;
                    s_tdata <= {2'b00, code_items[0].len, code_items[0].bits};
                end
            end
        end
    end

    // Receiver: random stalls, or a long counted hold-off when one is asked for
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (holds_asked != holds_granted)
            begin
                holds_granted++;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall);
        end
    end

    // Monitor: checks each output transaction, then predicts from each input transaction
    always @(posedge clk)
    begin : watch
        packed_byte_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (bytes_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected byte %02h last %b", $realtime, m_tdata, m_tlast);
                    mismatches++;
                end
                else
                begin
                    want = bytes_due.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.last)
                    begin
                        if (mismatches < 10)
                            $display("%0t: byte expected %02h last %b, got %02h last %b",
                                     $realtime, want.value, want.last, m_tdata, m_tlast);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                pack_code_bits(opcode_t'(s_tuser), s_tdata[31:0], s_tdata[37:32]);
                sink_stall = code_items[0].sink_stall;
                if (code_items[0].hold_sink)
                    holds_asked++;
                n_taken++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int unsigned src_pct;
        int unsigned stall_pct;
        int unsigned r;
        logic [5:0]  len;
        opcode_t     op;

        // Directed: empty-store end, zero length, stray bits, full and overlong codes,
        // seven bits pending into a 32-bit code, padding at end of stream
        add_item(OP_END,  32'h0000_0000, 6'd0,  0, 0, 0, 0);
        add_item(OP_CODE, 32'hFFFF_FFFF, 6'd0,  0, 0, 0, 0);
        add_item(OP_CODE, 32'h0000_0001, 6'd1,  0, 0, 0, 0);
        add_item(OP_CODE, 32'hFFFF_FF2A, 6'd7,  0, 0, 0, 0);
        add_item(OP_CODE, 32'h0000_00A5, 6'd8,  0, 0, 0, 0);
        add_item(OP_CODE, 32'hFFFF_FFFD, 6'd3,  0, 0, 0, 0);
        add_item(OP_CODE, 32'hFFFF_FFFF, 6'd32, 0, 0, 0, 0);
        add_item(OP_CODE, 32'h0000_000F, 6'd4,  0, 0, 0, 0);
        add_item(OP_CODE, 32'h0000_0000, 6'd32, 0, 0, 0, 0);
        add_item(OP_END,  32'h0000_0000, 6'd0,  0, 0, 0, 0);
        add_item(OP_CODE, 32'hDEAD_BEEF, 6'd33, 0, 0, 0, 0);
        add_item(OP_CODE, 32'h1234_5678, 6'd63, 0, 0, 0, 0);
        add_item(OP_CODE, 32'h0000_003F, 6'd6,  0, 0, 0, 0);
        add_item(OP_END,  32'h0000_0000, 6'd0,  0, 0, 0, 0);
        add_item(OP_CODE, 32'hA5A5_A5A5, 6'd32, 0, 0, 0, 0);
        add_item(OP_CODE, 32'hFFFF_FF80, 6'd7,  0, 0, 0, 0);
        add_item(OP_END,  32'h0000_0000, 6'd0,  0, 0, 0, 0);
        add_item(OP_END,  32'hFFFF_FFFF, 6'd63, 0, 0, 0, 0);
        add_item(OP_CODE, 32'hFFFF_FFFE, 6'd1,  0, 0, 0, 0);
        add_item(OP_END,  32'h0000_0000, 6'd0,  0, 0, 0, 0);

        // Random: mostly short and mid-length codes with an occasional end of stream,
        // a few zero and overlong lengths; flow control rotates through four phases
        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ((i / 45) % 4)
                0: begin src_pct = 0;  stall_pct = 0;  end
                1: begin src_pct = 47; stall_pct = 0;  end
                2: begin src_pct = 0;  stall_pct = 47; end
                default: begin src_pct = 13; stall_pct = 13; end
            endcase
            r = $urandom_range(99);
            if (r < 5)
                len = 6'd0;
            else if (r < 55)
                len = 6'($urandom_range(8, 1));
            else if (r < 80)
                len = 6'($urandom_range(16, 9));
            else if (r < 93)
                len = 6'($urandom_range(32, 17));
            else
                len = 6'($urandom_range(63, 33));
            op = ($urandom_range(99) < 8) ? OP_END : OP_CODE;
            add_item(op, 32'($urandom), len, src_pct, stall_pct,
                     (i == 95 || i == 300), (i == 10 || i == 190));
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (code_items.size() != 0)
            @(posedge clk);
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
